/* sv/serpentine_error_diffusion_halftone_top_assert.svh */
// Assertion macros for the serpentine error diffusion halftoner.
// Used by the top level; relies on signals named clk and rst_n in scope.
`ifndef SERPENTINE_ERROR_DIFFUSION_HALFTONE_TOP_ASSERT_SVH
`define SERPENTINE_ERROR_DIFFUSION_HALFTONE_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SEDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sedh_pkg.sv */
// Shared constants and types for the serpentine error diffusion halftoner.
// No dependencies; imported by the diffusion datapath and the top level.
`default_nettype none

package sedh_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int ERR_BITS_DEF   = 12;

  localparam int NUM_CH    = 3;
  localparam int SAMPLE_W  = 8;
  localparam int GEOM_W    = 11;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 2;

  // Errors are held in sixteenths of a level.
  localparam int ERR_SHIFT = 4;
  localparam int LEVEL_MAX = 255;

  localparam logic [GEOM_W-1:0]   FRAME_WIDTH_RST  = 11'd720;
  localparam logic [GEOM_W-1:0]   FRAME_HEIGHT_RST = 11'd480;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST    = 8'd128;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  // Position flags of the pixel being diffused.
  typedef struct packed {
    logic first;     // first pixel of its row in scan order
    logic row0;      // first row of the frame: nothing pending from above
    logic last_col;  // last pixel of its row in scan order
  } s1_ctl_t;

endpackage

`default_nettype wire

/* sv/serpentine_error_diffusion_halftone_top.sv */
// Serpentine Floyd-Steinberg error diffusion halftoner, top level.
// Depends on sedh_pkg, sedh_ram, sedh_diffuse and the assertion macro header.
//
// The input channel (in_valid, in_stall) carries one RGB pixel per item in
// serpentine scan order: even rows left to right, odd rows right to left.
// The result channel (out_valid, out_stall) returns one item per pixel with
// the three halftoned channel bits and the row and frame end flags.
// An item is moved at a rising edge where valid is high and stall is low.
// The block takes one item per clock cycle when the receiver keeps up. A
// taken item goes into the diffusion stage while its line store read starts;
// the diffusion result is then loaded into the output register unless the
// receiver stalls. The line store does one read and one write per cycle,
// so nothing holds the rate below one pixel per clock.
// When the receiver stalls, the output register holds its item, the
// pixel behind it waits in the diffusion stage and in_stall rises.
// Reset returns geometry and threshold to 720 x 480 and 128 and starts a
// new frame; no clearing pass is needed, as the first row of a frame ignores
// what it reads from the line store. A write to frame_width or frame_height also starts
// a new frame; threshold writes take effect on the next pixel. Registers lie
// at byte addresses 0 (frame_width), 4 (frame_height) and 8 (threshold).
`default_nettype none

module serpentine_error_diffusion_halftone_top #(
  parameter int MAX_WIDTH  = sedh_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sedh_pkg::MAX_HEIGHT_DEF,
  parameter int ERR_BITS   = sedh_pkg::ERR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sedh_pkg::SAMPLE_W-1:0] in_red_in,
  input  logic [sedh_pkg::SAMPLE_W-1:0] in_green_in,
  input  logic [sedh_pkg::SAMPLE_W-1:0] in_blue_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_red_on,
  output logic                          out_green_on,
  output logic                          out_blue_on,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sedh_pkg::CFG_AW-1:0]   paddr,
  input  logic [sedh_pkg::CFG_DW-1:0]   pwdata,
  output logic [sedh_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  import sedh_pkg::*;

`include "serpentine_error_diffusion_halftone_top_assert.svh"

  localparam int PW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int AW  = $clog2(2 * MAX_WIDTH);
  localparam int MW  = NUM_CH * ERR_BITS;
  localparam int WCW = (PW + 1 > GEOM_W) ? PW + 1 : GEOM_W;
  localparam int HCW = (RW + 1 > GEOM_W) ? RW + 1 : GEOM_W;

  // Configuration registers.
  logic [GEOM_W-1:0]    frame_width_r, frame_height_r;
  logic [SAMPLE_W-1:0]  threshold_r;
  logic                 cfg_wr, restart;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  // A geometry change starts a fresh frame with no pending error.
  assign restart = cfg_wr && (reg_idx == REG_FRAME_WIDTH || reg_idx == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      threshold_r    <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[GEOM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[GEOM_W-1:0];
        REG_THRESHOLD:    threshold_r    <= pwdata[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DW'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(frame_height_r);
      REG_THRESHOLD:    prdata = CFG_DW'(threshold_r);
      default:          prdata = '0;
    endcase
  end

  // Effective geometry: the programmed size clamped to 1..MAX. Only the last
  // column and last row indexes are needed.
  logic [WCW-1:0] fw_e, w_clamp;
  logic [HCW-1:0] fh_e, h_clamp;
  logic [PW-1:0]  wm1;
  logic [RW-1:0]  hm1;

  always_comb begin
    fw_e = WCW'(frame_width_r);
    fh_e = HCW'(frame_height_r);
    if (fw_e == '0) begin
      w_clamp = WCW'(1);
    end else if (fw_e > WCW'(MAX_WIDTH)) begin
      w_clamp = WCW'(MAX_WIDTH);
    end else begin
      w_clamp = fw_e;
    end
    if (fh_e == '0) begin
      h_clamp = HCW'(1);
    end else if (fh_e > HCW'(MAX_HEIGHT)) begin
      h_clamp = HCW'(MAX_HEIGHT);
    end else begin
      h_clamp = fh_e;
    end
    wm1 = PW'(w_clamp - WCW'(1));
    hm1 = RW'(h_clamp - HCW'(1));
  end

  // Scan position of the next item to be taken.
  logic [PW-1:0] col_pos_r;
  logic [RW-1:0] row_pos_r;
  logic          last_col, last_row, rev;
  logic [PW-1:0] x_cur;
  logic          in_accept;

  assign last_col = (col_pos_r == wm1);
  assign last_row = (row_pos_r == hm1);
  // Odd rows run right to left and read line bank 1.
  assign rev      = row_pos_r[0];
  assign x_cur    = rev ? (wm1 - col_pos_r) : col_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_pos_r <= '0;
        row_pos_r <= last_row ? '0 : row_pos_r + RW'(1);
      end else begin
        col_pos_r <= col_pos_r + PW'(1);
      end
    end
  end

  // Diffusion stage: the taken pixel waits here while its pending error is
  // read from the line store.
  logic                s1_valid_r;
  s1_ctl_t             s1_ctl_r;
  logic                s1_last_row_r, s1_rev_r;
  logic [PW-1:0]       s1_x_r;
  logic [SAMPLE_W-1:0] s1_smp_r [NUM_CH];
  logic                s1_adv;

  // Output register.
  logic              out_valid_r;
  logic [NUM_CH-1:0] out_on_r;
  logic              out_row_end_r, out_frame_end_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctl_r.first    <= (col_pos_r == '0);
      s1_ctl_r.row0     <= (row_pos_r == '0);
      s1_ctl_r.last_col <= last_col;
      s1_last_row_r     <= last_row;
      s1_rev_r          <= rev;
      s1_x_r            <= x_cur;
      s1_smp_r[0]       <= in_red_in;
      s1_smp_r[1]       <= in_green_in;
      s1_smp_r[2]       <= in_blue_in;
    end
  end

  // Line store: two banks of MAX_WIDTH entries, three errors per entry.
  // The current row reads its own bank; the finished entry one step behind
  // the scan is written to the other bank. The last entry of a row is never
  // written: the next row consumes it first, straight from the window.
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [MW-1:0] ram_wr_data, ram_rd_data;
  logic [PW-1:0] wr_x;

  assign ram_rd_addr = rev ? (AW'(MAX_WIDTH) + AW'(x_cur)) : AW'(x_cur);
  assign wr_x        = s1_rev_r ? (s1_x_r + PW'(1)) : (s1_x_r - PW'(1));
  assign ram_wr_addr = s1_rev_r ? AW'(wr_x) : (AW'(MAX_WIDTH) + AW'(wr_x));
  // Shares for the row below are dropped on the last row.
  assign ram_wr_en   = s1_adv && !s1_ctl_r.first && !s1_last_row_r;

  sedh_ram #(
    .WIDTH (MW),
    .DEPTH (2 * MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_accept),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  logic [NUM_CH-1:0] ch_on;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    sedh_diffuse #(
      .ERR_BITS (ERR_BITS)
    ) u_diffuse (
      .clk       (clk),
      .rst_n     (rst_n),
      .restart   (restart),
      .adv       (s1_adv),
      .ctl       (s1_ctl_r),
      .threshold (threshold_r),
      .sample    (s1_smp_r[c]),
      .mem_err   (ram_rd_data[c*ERR_BITS +: ERR_BITS]),
      .on        (ch_on[c]),
      .final_err (ram_wr_data[c*ERR_BITS +: ERR_BITS])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_on_r        <= ch_on;
      out_row_end_r   <= s1_ctl_r.last_col;
      out_frame_end_r <= s1_ctl_r.last_col && s1_last_row_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_on    = out_on_r[0];
  assign out_green_on  = out_on_r[1];
  assign out_blue_on   = out_on_r[2];
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  `SEDH_ASSERT_NEXT(a_col_wrap, in_accept && last_col, col_pos_r == '0, "column did not wrap")
  `SEDH_ASSERT_NEXT(a_frame_wrap, in_accept && last_col && last_row, row_pos_r == '0, "row kept")
  `SEDH_ASSERT_NEXT(a_s1_fill, in_accept, s1_valid_r, "taken item missing from diffusion stage")
  `SEDH_ASSERT_NEXT(a_out_fill, s1_adv, out_valid_r, "diffused item missing from output register")

endmodule

`default_nettype wire

/* sv/sedh_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the pending error line store.
`default_nettype none

module sedh_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/sedh_diffuse.sv */
// Per-channel error diffusion datapath: threshold, residual and error shares.
// Depends on sedh_pkg; holds the carry to the next pixel and the row-below window.
`default_nettype none

module sedh_diffuse #(
  parameter int ERR_BITS = sedh_pkg::ERR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  logic                            adv,
  input  sedh_pkg::s1_ctl_t               ctl,
  input  logic [sedh_pkg::SAMPLE_W-1:0]   threshold,
  input  logic [sedh_pkg::SAMPLE_W-1:0]   sample,
  input  logic signed [ERR_BITS-1:0]      mem_err,
  output logic                            on,
  output logic signed [ERR_BITS-1:0]      final_err
);

  import sedh_pkg::*;

  localparam int SW = ERR_BITS + 1;

  logic signed [ERR_BITS-1:0] carry_r, carry_nxt;
  logic signed [ERR_BITS-1:0] win_a_r, win_a_nxt;
  logic signed [ERR_BITS-1:0] win_b_r, win_b_nxt;
  logic signed [ERR_BITS-1:0] cur_err, win_b_eff;
  logic signed [SW-1:0]       sum, flr, lvl, lvl_ext, e_x, e3, e5, e7;
  logic [SAMPLE_W-1:0]        clamped;

  function automatic logic signed [ERR_BITS-1:0] sat_err(input logic signed [SW-1:0] v);
    logic signed [ERR_BITS-1:0] r;
    if (v[SW-1] != v[SW-2]) begin
      r = v[SW-1] ? {1'b1, {(ERR_BITS-1){1'b0}}} : {1'b0, {(ERR_BITS-1){1'b1}}};
    end else begin
      r = v[ERR_BITS-1:0];
    end
    return r;
  endfunction

  // The first pixel of a row takes its pending error from the window, which
  // still holds the last entry finished by the previous row.
  assign cur_err = ctl.row0 ? '0 : (ctl.first ? win_a_r : mem_err);

  always_comb begin
    sum = SW'(cur_err) + SW'(carry_r);
    flr = sum >>> ERR_SHIFT;
    lvl = SW'($signed({1'b0, sample})) + flr;
    if (lvl[SW-1]) begin
      clamped = '0;
    end else if (lvl > SW'(LEVEL_MAX)) begin
      clamped = SAMPLE_W'(LEVEL_MAX);
    end else begin
      clamped = lvl[SAMPLE_W-1:0];
    end
    on      = (clamped >= threshold);
    lvl_ext = SW'({1'b0, clamped});
    e_x     = on ? (lvl_ext - SW'(LEVEL_MAX)) : lvl_ext;
    e3      = (e_x <<< 1) + e_x;
    e5      = (e_x <<< 2) + e_x;
    e7      = (e_x <<< 3) - e_x;
  end

  assign win_b_eff = ctl.first ? '0 : win_b_r;
  assign final_err = sat_err(SW'(win_a_r) + e3);
  assign win_a_nxt = sat_err(SW'(win_b_eff) + e5);
  assign win_b_nxt = sat_err(e_x);
  assign carry_nxt = ctl.last_col ? '0 : sat_err(e7);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      carry_r <= '0;
    end else if (adv) begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_a_r <= win_a_nxt;
      win_b_r <= win_b_nxt;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the serpentine error diffusion halftoner.
// Depends on sedh_pkg and serpentine_error_diffusion_halftone_top only.

module tb_top;
  import sedh_pkg::*;

  // Geometry and error widths of the block as built with its defaults.
  localparam int MAXW   = MAX_WIDTH_DEF;
  localparam int MAXH   = MAX_HEIGHT_DEF;
  localparam int EBITS  = ERR_BITS_DEF;
  localparam int ERR_HI = (1 << (EBITS - 1)) - 1;
  localparam int ERR_LO = -ERR_HI - 1;

  // Register index that decodes to nothing: writes to it must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Settling time after the last dot has come back. A result passes through
  // the diffusion stage and the output register after its input is taken.
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 700;

  typedef logic signed [EBITS-1:0] err_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic row_end;
    logic frame_end;
  } dot_t;

  // Flavours of random picture content.
  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_FLAT} pixel_mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_red_in   = '0;
  logic [SAMPLE_W-1:0] in_green_in = '0;
  logic [SAMPLE_W-1:0] in_blue_in  = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic                out_red_on;
  logic                out_green_on;
  logic                out_blue_on;
  logic                out_row_end;
  logic                out_frame_end;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CFG_AW-1:0]   paddr       = '0;
  logic [CFG_DW-1:0]   pwdata      = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  serpentine_error_diffusion_halftone_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_on   (out_red_on),
    .out_green_on (out_green_on),
    .out_blue_on  (out_blue_on),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Halftone predictor. It keeps its own copy of the two line banks of pending
  // error, the error carried to the next pixel in the scan, the scan position
  // and the three registers, and works out the dots of every pixel that the
  // block accepts, in the order of acceptance.
  // ---------------------------------------------------------------------------
  err_t                line_err  [0:2*MAXW-1][0:NUM_CH-1];
  err_t                carry_err [0:NUM_CH-1];
  int                  col_pos;
  int                  row_pos;
  logic [GEOM_W-1:0]   width_reg;
  logic [GEOM_W-1:0]   height_reg;
  logic [SAMPLE_W-1:0] thresh_reg;

  pixel_t pixel_q[$];       // pixels waiting to be offered to the block
  dot_t   expected_dots[$]; // predicted dots, oldest first
  int     errors = 0;
  bit     steady = 1'b0;    // when set, neither side idles nor stalls
  pixel_t next_pix;
  dot_t   got_dot;

  // Stored errors saturate at the signed range of the error word.
  function automatic err_t clip_err(input int v);
    if (v > ERR_HI) return err_t'(ERR_HI);
    if (v < ERR_LO) return err_t'(ERR_LO);
    return err_t'(v);
  endfunction

  // Out-of-range geometry is clamped rather than rejected.
  function automatic int active_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAXW) return MAXW;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg < 1) return 1;
    if (height_reg > MAXH) return MAXH;
    return int'(height_reg);
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < 2 * MAXW; i++)
      for (int c = 0; c < NUM_CH; c++) line_err[i][c] = '0;
    for (int c = 0; c < NUM_CH; c++) carry_err[c] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Adds a share to the row below; shares beyond either edge are dropped.
  function automatic void spread_below(input int bank, input int x, input int w,
                                       input int ch, input int amount);
    int slot;
    if (x < 0 || x >= w) return;
    slot = bank * MAXW + x;
    line_err[slot][ch] = clip_err(int'(line_err[slot][ch]) + amount);
  endfunction

  // A geometry write starts a fresh frame; a threshold write does not.
  function automatic void note_register(input logic [REG_IDX_W-1:0] idx,
                                        input logic [CFG_DW-1:0] val);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = val[GEOM_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = val[GEOM_W-1:0];
        restart_frame();
      end
      REG_THRESHOLD: begin
        thresh_reg = val[SAMPLE_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic dot_t halftone_pixel(input pixel_t pix);
    int                  w, h, pos, row, x, step, cur, nxt, slot, acc, lvl, resid;
    logic                reverse, last_col, last_row, on;
    logic [SAMPLE_W-1:0] smp [0:NUM_CH-1];
    logic [NUM_CH-1:0]   dots;
    dot_t                res;
    w        = active_width();
    h        = active_height();
    pos      = (col_pos >= w) ? w - 1 : col_pos;
    row      = (row_pos >= h) ? h - 1 : row_pos;
    reverse  = row[0];
    x        = reverse ? w - 1 - pos : pos;
    step     = reverse ? -1 : 1;
    last_col = (pos == w - 1);
    last_row = (row == h - 1);
    cur      = row & 1;
    nxt      = cur ^ 1;
    slot     = cur * MAXW + x;
    smp[0]   = pix.red;
    smp[1]   = pix.green;
    smp[2]   = pix.blue;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = int'(line_err[slot][ch]) + int'(carry_err[ch]);
      // Arithmetic shift of a signed int floors towards minus infinity.
      acc = acc >>> ERR_SHIFT;
      lvl = acc + int'(smp[ch]);
      line_err[slot][ch] = '0;
      if (lvl < 0) lvl = 0;
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      on       = (lvl >= int'(thresh_reg));
      resid    = on ? lvl - LEVEL_MAX : lvl;
      dots[ch] = on;
      carry_err[ch] = last_col ? err_t'(0) : clip_err(7 * resid);
      if (!last_row) begin
        spread_below(nxt, x - step, w, ch, 3 * resid);
        spread_below(nxt, x, w, ch, 5 * resid);
        spread_below(nxt, x + step, w, ch, resid);
      end
    end
    res.red       = dots[0];
    res.green     = dots[1];
    res.blue      = dots[2];
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = pos + 1;
      row_pos = row;
    end
    return res;
  endfunction

  function automatic void check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver. An item is offered from the pending queue and held steady
  // while the block stalls. The prediction is made at the edge where the item
  // is taken, so the predictor sees pixels in exactly the block's order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_dots.push_back(halftone_pixel('{in_red_in, in_green_in, in_blue_in}));
      end
      if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
        next_pix    = pixel_q.pop_front();
        in_valid    <= 1'b1;
        in_red_in   <= next_pix.red;
        in_green_in <= next_pix.green;
        in_blue_in  <= next_pix.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Dot monitor. Every item taken from the result channel is compared field by
  // field with the oldest prediction. The receiver stalls at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dots.size() == 0) begin
          $error("dot item arrived with no prediction waiting");
          errors++;
        end else begin
          got_dot = expected_dots.pop_front();
          check_bit("red_on", got_dot.red, out_red_on);
          check_bit("green_on", got_dot.green, out_green_on);
          check_bit("blue_on", got_dot.blue, out_blue_on);
          check_bit("row_end", got_dot.row_end, out_row_end);
          check_bit("frame_end", got_dot.frame_end, out_frame_end);
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 16);
    end
  end

  // APB write: setup cycle, then access until pready. The register takes the
  // value at the edge that ends the access, and the predictor follows suit.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    note_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Blocks until every pending pixel has been taken and every dot has come
  // back, then lets the pipeline settle.
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || expected_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample(input pixel_mix_t mix,
                                                        input int level);
    int v;
    case (mix)
      MIX_EXTREME: v = $urandom_range(1) ? $urandom_range(250, 255) : $urandom_range(0, 5);
      MIX_FLAT: begin
        v = level + $urandom_range(16) - 8;
        if (v < 0) v = 0;
        if (v > LEVEL_MAX) v = LEVEL_MAX;
      end
      default: v = $urandom_range(255);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic pixel_t random_pixel(input pixel_mix_t mix, input int level);
    return '{random_sample(mix, level), random_sample(mix, level), random_sample(mix, level)};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus. A short directed part hits the corners, then random phases each
  // pick a geometry and threshold while the block is idle and push one or more
  // frames of pixels. Phases are kept small so that frame ends, reverse rows,
  // both image edges and the last-row rule all come round often.
  // ---------------------------------------------------------------------------
  initial begin
    int         sent, phase, sel, wv, hv, thr, frame, n, level;
    pixel_mix_t mix;
    bit         fresh;

    // Predictor starts from the register reset values and an empty store.
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    thresh_reg = THRESHOLD_RST;
    restart_frame();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry and threshold: sample extremes, both sides of the
    // default threshold and alternating bit patterns, part way into a row.
    pixel_q.push_back('{8'd0, 8'd0, 8'd0});
    pixel_q.push_back('{8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{8'd128, 8'd127, 8'd128});
    pixel_q.push_back('{8'd127, 8'd128, 8'd127});
    pixel_q.push_back('{8'hAA, 8'h55, 8'hAA});
    pixel_q.push_back('{8'h55, 8'hAA, 8'h55});
    wait_drained();

    // Threshold zero over a black 3 x 3 image: every dot is on with the
    // largest negative residual, so the line store saturates on row one and
    // the combined error floors well below zero. Also the mid-frame restart.
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_FRAME_WIDTH, 32'd3);
    write_reg(REG_FRAME_HEIGHT, 32'd3);
    repeat (9) pixel_q.push_back('{8'd0, 8'd0, 8'd0});
    wait_drained();

    // Zero geometry clamps to a single pixel: every item ends row and frame.
    write_reg(REG_THRESHOLD, 32'd128);
    write_reg(REG_FRAME_WIDTH, 32'd0);
    write_reg(REG_FRAME_HEIGHT, 32'd0);
    pixel_q.push_back('{8'd200, 8'd10, 8'd128});
    pixel_q.push_back('{8'd127, 8'd255, 8'd0});
    pixel_q.push_back('{8'd128, 8'd128, 8'd128});
    wait_drained();

    // A write to the unused address must change nothing; then the largest
    // geometry the register holds, clamped to the line store size, with the
    // highest threshold so that only full-scale samples turn on.
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_FRAME_WIDTH, 32'hFFFF_F7FF);
    write_reg(REG_FRAME_HEIGHT, 32'h0000_07FF);
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    pixel_q.push_back('{8'd255, 8'd254, 8'd255});
    pixel_q.push_back('{8'd254, 8'd255, 8'd0});
    pixel_q.push_back('{8'd255, 8'd255, 8'd255});
    wait_drained();

    // Random phases.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      fresh = 1'b0;
      if (phase == 0 || $urandom_range(3) != 0) begin
        sel = $urandom_range(15);
        if (sel == 0)      wv = 2;
        else if (sel == 1) wv = $urandom_range(1) ? MAXW : 2047;
        else if (sel == 2) wv = $urandom_range(1);
        else               wv = $urandom_range(3, 16);
        sel = $urandom_range(15);
        if (sel == 0)      hv = $urandom_range(1) ? MAXH : 2047;
        else if (sel == 1) hv = 0;
        else               hv = $urandom_range(1, 5);
        // Junk above the register width must be dropped by the block.
        write_reg(REG_FRAME_WIDTH, (32'(wv) & 32'h7FF) | ($urandom() << GEOM_W));
        write_reg(REG_FRAME_HEIGHT, (32'(hv) & 32'h7FF) | ($urandom() << GEOM_W));
        fresh = 1'b1;
      end
      // A threshold-only phase carries on mid-frame with the stored error.
      sel = $urandom_range(7);
      thr = (sel == 0) ? 0 : (sel == 1) ? LEVEL_MAX : $urandom_range(255);
      write_reg(REG_THRESHOLD, 32'(thr) | ($urandom() << SAMPLE_W));

      frame = active_width() * active_height();
      if (fresh) begin
        n = frame * $urandom_range(1, 2);
        if ($urandom_range(2) == 0) n += $urandom_range(frame - 1);
      end else begin
        n = $urandom_range(5, 60);
      end
      if (n > 150) n = 150;
      // One long phase runs with no idling on either side.
      steady = (phase == 2);
      if (steady) n = 150;
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;

      mix   = pixel_mix_t'($urandom_range(2));
      level = $urandom_range(255);
      for (int i = 0; i < n; i++) begin
        // Now and then the sender holds off mid-frame until all dots are back.
        if (phase % 4 == 1 && i == n / 2) wait_drained();
        pixel_q.push_back(random_pixel(mix, level));
      end
      sent += n;
      wait_drained();
      steady = 1'b0;
      phase++;
    end

    wait_drained();
    if (errors == 0 && expected_dots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/sedh_pkg.sv
sv/sedh_ram.sv
sv/sedh_diffuse.sv
sv/serpentine_error_diffusion_halftone_top.sv
dv/tb_top.sv
